// ----- rtl/b64u_pkg.sv -----
// Shared types, constants and the character lookup for the base64url encoder.
// No dependencies; every other file imports this package.
`default_nettype none

package b64u_pkg;

	localparam int unsigned QueueDepthDefault = 4;

	localparam int unsigned SextetW = 6;
	localparam int unsigned CharW   = 7;

	// ASCII anchors of the URL-safe alphabet
	localparam logic [CharW-1:0] AsciiUpperA = 7'h41;
	localparam logic [CharW-1:0] AsciiLowerA = 7'h61;
	localparam logic [CharW-1:0] AsciiZero   = 7'h30;
	localparam logic [CharW-1:0] AsciiDash   = 7'h2D;
	localparam logic [CharW-1:0] AsciiUnder  = 7'h5F;

	localparam logic [SextetW-1:0] SextetLowerStart = 6'd26;
	localparam logic [SextetW-1:0] SextetDigitStart = 6'd52;
	localparam logic [SextetW-1:0] SextetDash       = 6'd62;
	localparam logic [SextetW-1:0] SextetUnder      = 6'd63;

	// Group phase codes
	localparam logic [1:0] PhaseFirst  = 2'd0;
	localparam logic [1:0] PhaseSecond = 2'd1;
	localparam logic [1:0] PhaseThird  = 2'd2;

	// One accepted byte after classification: one or two sextets
	typedef struct packed {
		logic [SextetW-1:0] sext0;
		logic [SextetW-1:0] sext1;
		logic               has2;
		logic               last;
	} entry_t;

	function automatic logic [CharW-1:0] sextet_to_char(input logic [SextetW-1:0] s);
		logic [CharW-1:0] v;
		v = {1'b0, s};
		if (s < SextetLowerStart)
			return AsciiUpperA + v;
		else if (s < SextetDigitStart)
			return AsciiLowerA + v - {1'b0, SextetLowerStart};
		else if (s < SextetDash)
			return AsciiZero + v - {1'b0, SextetDigitStart};
		else if (s == SextetDash)
			return AsciiDash;
		else
			return AsciiUnder;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/b64u_front.sv -----
// Front end: accepts bytes, tracks group phase and carried bits, forms sextets.
// Depends on b64u_pkg.
`default_nettype none

module b64u_front
	import b64u_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	input  wire logic [7:0] data_byte,
	input  wire logic       final_byte,
	input  wire logic       q_full,
	output logic            q_wr,
	output entry_t          q_wr_data
);

	logic [1:0] phase_q;
	logic [3:0] carry_q;
	logic [1:0] phase_nxt;
	logic [3:0] carry_nxt;

	assign q_wr = push && !q_full;

	always_comb begin
		q_wr_data.last = final_byte;
		unique case (phase_q)
			PhaseSecond: begin
				q_wr_data.sext0 = {carry_q[1:0], data_byte[7:4]};
				q_wr_data.sext1 = {data_byte[3:0], 2'b00};
				q_wr_data.has2  = final_byte;
				carry_nxt       = data_byte[3:0];
				phase_nxt       = PhaseThird;
			end
			PhaseThird: begin
				q_wr_data.sext0 = {carry_q, data_byte[7:6]};
				q_wr_data.sext1 = data_byte[5:0];
				q_wr_data.has2  = 1'b1;
				carry_nxt       = 4'd0;
				phase_nxt       = PhaseFirst;
			end
			default: begin
				q_wr_data.sext0 = data_byte[7:2];
				q_wr_data.sext1 = {data_byte[1:0], 4'b0000};
				q_wr_data.has2  = final_byte;
				carry_nxt       = {2'b00, data_byte[1:0]};
				phase_nxt       = PhaseSecond;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PhaseFirst;
			carry_q <= 4'd0;
		end else if (q_wr) begin
			// final byte closes the message: restart the group
			if (final_byte) begin
				phase_q <= PhaseFirst;
				carry_q <= 4'd0;
			end else begin
				phase_q <= phase_nxt;
				carry_q <= carry_nxt;
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/b64u_queue.sv -----
// Short request queue between front and back end.
// Depends on b64u_pkg for the entry type.
`default_nettype none

module b64u_queue
	import b64u_pkg::*;
#(
	parameter int unsigned Depth = QueueDepthDefault
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   wr,
	input  wire entry_t wr_data,
	output logic        full,
	input  wire logic   rd,
	output entry_t      rd_data,
	output logic        empty
);

	localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int unsigned CntW  = $clog2(Depth + 1);
	localparam logic [AddrW-1:0] LastAddr = AddrW'(Depth - 1);
	localparam logic [CntW-1:0]  DepthCnt = CntW'(Depth);

	entry_t           mem_q [Depth];
	logic [AddrW-1:0] wr_ptr_q;
	logic [AddrW-1:0] rd_ptr_q;
	logic [CntW-1:0]  count_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (count_q == DepthCnt);
	assign empty   = (count_q == '0);
	assign do_wr   = wr && !full;
	assign do_rd   = rd && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr)
			mem_q[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr)
				wr_ptr_q <= (wr_ptr_q == LastAddr) ? '0 : wr_ptr_q + 1'b1;
			if (do_rd)
				rd_ptr_q <= (rd_ptr_q == LastAddr) ? '0 : rd_ptr_q + 1'b1;
			if (do_wr && !do_rd)
				count_q <= count_q + 1'b1;
			else if (do_rd && !do_wr)
				count_q <= count_q - 1'b1;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DepthCnt) else $error("queue count above depth");

	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(do_wr && !do_rd) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue count missed a write");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(do_rd && !do_wr) |=> (count_q == $past(count_q) - 1'b1))
		else $error("queue count missed a read");

	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(empty || full) |-> (wr_ptr_q == rd_ptr_q))
		else $error("queue pointers disagree with count");

endmodule

`default_nettype wire

// ----- rtl/b64u_back.sv -----
// Back end: serializes queued sextets, maps them to ASCII, holds the result register.
// Depends on b64u_pkg.
`default_nettype none

module b64u_back
	import b64u_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire entry_t      q_rd_data,
	input  wire logic        q_empty,
	output logic             q_rd,
	input  wire logic        pop,
	output logic             empty,
	output logic [CharW-1:0] out_char,
	output logic             last_char
);

	logic             idx_q;
	logic             out_valid_q;
	logic [CharW-1:0] char_q;
	logic             last_q;
	logic             load;
	logic             entry_done;
	logic [SextetW-1:0] sext;

	assign empty      = !out_valid_q;
	assign out_char   = char_q;
	assign last_char  = last_q;
	assign load       = !q_empty && (!out_valid_q || pop);
	assign entry_done = idx_q || !q_rd_data.has2;
	assign q_rd       = load && entry_done;
	assign sext       = idx_q ? q_rd_data.sext1 : q_rd_data.sext0;

	always_ff @(posedge clk) begin
		if (load) begin
			char_q <= sextet_to_char(sext);
			last_q <= entry_done && q_rd_data.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				// advance to second sextet, or back to the first on the next entry
				idx_q       <= !entry_done;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_idx_needs_pair: assert property (@(posedge clk) disable iff (!arst_n)
		(idx_q && !q_empty) |-> q_rd_data.has2)
		else $error("second sextet selected on a single-sextet entry");

	a_idx_holds_entry: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q |-> !q_empty) else $error("mid-entry with queue drained");

	a_last_on_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(load && !entry_done) |=> !last_q)
		else $error("last flag set on first sextet of a pair");

endmodule

`default_nettype wire

// ----- rtl/base64url_stream_encoder.sv -----
// base64url_stream_encoder: byte stream to URL-safe base64 characters, no padding.
// Channels: input queue (push/full) carries data_byte and final_byte; result queue
// (empty/pop) carries out_char and last_char, the oldest character first.
// Each byte yields one character, or two at the end of a three-byte group and
// on a flagged final byte; last_char marks the closing character of a message.
// With the result register free, the first character of a byte passes through
// the entry queue and then the result register before it becomes visible.
// Throughput: one character per cycle while pop is high, set by the single
// result register, so a byte's one or two characters leave in turn. The front
// end keeps taking bytes while results wait, until the entry queue (QueueDepth
// entries) fills, then raises full.
// Reset clears group phase, carried bits, queue and result register; the next
// byte starts a new group. While pop stays low the current character holds.
// Depends on b64u_pkg, b64u_front, b64u_queue, b64u_back.
`default_nettype none

module base64url_stream_encoder
	import b64u_pkg::*;
#(
	parameter int unsigned QueueDepth = QueueDepthDefault
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	output logic                  full,
	input  wire logic [7:0]       data_byte,
	input  wire logic             final_byte,
	output logic                  empty,
	input  wire logic             pop,
	output logic [CharW-1:0]      out_char,
	output logic                  last_char
);

	entry_t wr_data;
	entry_t rd_data;
	logic   q_wr;
	logic   q_rd;
	logic   q_empty;

	b64u_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.data_byte (data_byte),
		.final_byte(final_byte),
		.q_full    (full),
		.q_wr      (q_wr),
		.q_wr_data (wr_data)
	);

	b64u_queue #(
		.Depth(QueueDepth)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_wr),
		.wr_data(wr_data),
		.full   (full),
		.rd     (q_rd),
		.rd_data(rd_data),
		.empty  (q_empty)
	);

	b64u_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_rd_data(rd_data),
		.q_empty  (q_empty),
		.q_rd     (q_rd),
		.pop      (pop),
		.empty    (empty),
		.out_char (out_char),
		.last_char(last_char)
	);

endmodule

`default_nettype wire
